/* rtl/psca_pkg.sv */
// Shared types and constants of the page size-class allocator.
// No dependencies; the other files that use it refer to it by scoped names.
package psca_pkg;

  localparam int unsigned PAGES      = 8;
  localparam int unsigned SLOTS      = 16;
  localparam logic [3:0]  PAGE_LG    = 4'd8;
  localparam logic [4:0]  MIN_LG     = 5'd4;
  localparam logic [4:0]  SPLIT_LG   = 5'd7;
  localparam logic [4:0]  MULTI_LG   = 5'd11;

  localparam logic [1:0]  FUNC_ALLOC   = 2'd0;
  localparam logic [1:0]  FUNC_FREE    = 2'd1;
  localparam logic [1:0]  FUNC_REALLOC = 2'd2;
  localparam logic [1:0]  FUNC_RSVD    = 2'd3;

  typedef enum logic [1:0] {
    KIND_FREE,
    KIND_SPLIT,
    KIND_MULTI
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOSPACE,
    ST_BADOFF
  } status_t;

  typedef enum logic [1:0] {
    PATH_ALLOC,
    PATH_FREE,
    PATH_REALLOC,
    PATH_BAD
  } path_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_ALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  lg;
    logic [15:0] used;
    logic        head;
  } page_t;

  typedef struct packed {
    logic capture;
    logic do_alloc;
    logic do_free;
    logic do_bad;
    logic do_realloc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    path_t path;
    logic  free_ok;
    logic  out_busy;
  } stat_t;

endpackage

/* rtl/psca_if.sv */
// Handshake channels of the allocator: request and response.
// Depends on nothing; payload widths are fixed.
interface psca_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] request_size;
  logic [10:0] block_offset;
  logic        offset_present;
  modport source (output valid, func, request_size, block_offset, offset_present,
                  input ready);
  modport sink (input valid, func, request_size, block_offset, offset_present,
                output ready);
endinterface

interface psca_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] result_offset;
  logic [1:0]  status;
  modport source (output valid, result_offset, status, input ready);
  modport sink (input valid, result_offset, status, output ready);
endinterface

/* rtl/psca_ctrl.sv */
// Sequencer of the allocator: steps one request through its phases.
// Depends on psca_pkg.
module psca_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  psca_pkg::stat_t  stat,
  output psca_pkg::cmd_t   cmd
);

  psca_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= psca_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      psca_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = psca_pkg::S_OP;
        end
      end
      psca_pkg::S_OP: begin
        state_next = psca_pkg::S_DONE;
        unique case (stat.path)
          psca_pkg::PATH_ALLOC: cmd.do_alloc = 1'b1;
          psca_pkg::PATH_FREE:  cmd.do_free  = 1'b1;
          psca_pkg::PATH_REALLOC: begin
            cmd.do_free = 1'b1;
            if (stat.free_ok) state_next = psca_pkg::S_ALLOC;
          end
          default: cmd.do_bad = 1'b1;
        endcase
      end
      psca_pkg::S_ALLOC: begin
        cmd.do_realloc = 1'b1;
        state_next     = psca_pkg::S_DONE;
      end
      psca_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = psca_pkg::S_IDLE;
        end
      end
      default: state_next = psca_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/psca_datapath.sv */
// Page table, snapshot, allocation and free logic, and the output register.
// Depends on psca_pkg and the channel interfaces.
module psca_datapath (
  input  logic              clk,
  input  logic              rst,
  psca_req_if.sink          req,
  psca_rsp_if.source        rsp,
  input  psca_pkg::cmd_t    cmd,
  output psca_pkg::stat_t   stat
);

  psca_pkg::page_t pool [psca_pkg::PAGES];
  psca_pkg::page_t snap [psca_pkg::PAGES];
  psca_pkg::page_t free_pool  [psca_pkg::PAGES];
  psca_pkg::page_t alloc_pool [psca_pkg::PAGES];

  logic [1:0]  func;
  logic [15:0] req_size;
  logic [10:0] boff;
  logic        present;
  logic [10:0] res_off;
  psca_pkg::status_t res_status;
  logic [10:0] out_off;
  psca_pkg::status_t out_status;
  logic        out_valid;

  // size class
  logic [15:0] size_m1;
  logic [4:0]  lg_req;
  always_comb begin
    size_m1 = req_size - 16'd1;
    lg_req  = psca_pkg::MIN_LG;
    if (req_size > 16'd16) begin
      for (int b = 0; b < 16; b++) begin
        if (size_m1[b]) lg_req = 5'(b + 1);
      end
    end
  end

  // allocation on the current table
  logic        alloc_ok;
  logic [10:0] alloc_off;
  logic [15:0] slot_mask;
  logic        hit_any, ff_any, run_any;
  logic [2:0]  hit_pg, ff_pg, run_pg;
  logic [15:0] avail;
  logic [3:0]  slot;
  logic [3:0]  n_pages;
  logic        run_ok;
  always_comb begin
    case (lg_req[1:0])
      2'd0:    slot_mask = 16'hFFFF;
      2'd1:    slot_mask = 16'h00FF;
      2'd2:    slot_mask = 16'h000F;
      default: slot_mask = 16'h0003;
    endcase
    hit_any = 1'b0;
    ff_any  = 1'b0;
    run_any = 1'b0;
    hit_pg  = '0;
    ff_pg   = '0;
    run_pg  = '0;
    n_pages = 4'd1 << lg_req[1:0];
    for (int i = psca_pkg::PAGES - 1; i >= 0; i--) begin
      if (pool[i].kind == psca_pkg::KIND_SPLIT && {1'b0, pool[i].lg} == lg_req &&
          (~pool[i].used & slot_mask) != 16'd0) begin
        hit_any = 1'b1;
        hit_pg  = 3'(i);
      end
      if (pool[i].kind == psca_pkg::KIND_FREE) begin
        ff_any = 1'b1;
        ff_pg  = 3'(i);
      end
      run_ok = 1'b1;
      for (int j = 0; j < psca_pkg::PAGES; j++) begin
        if (4'(j) < n_pages) begin
          if (i + j >= psca_pkg::PAGES) run_ok = 1'b0;
          else if (pool[(i + j) % psca_pkg::PAGES].kind != psca_pkg::KIND_FREE)
            run_ok = 1'b0;
        end
      end
      if (run_ok) begin
        run_any = 1'b1;
        run_pg  = 3'(i);
      end
    end
    avail = ~pool[hit_pg].used & slot_mask;
    slot  = '0;
    for (int b = psca_pkg::SLOTS - 1; b >= 0; b--) begin
      if (avail[b]) slot = 4'(b);
    end
    alloc_pool = pool;
    alloc_ok   = 1'b0;
    alloc_off  = '0;
    if (lg_req <= psca_pkg::SPLIT_LG) begin
      if (hit_any) begin
        alloc_ok = 1'b1;
        alloc_off = {hit_pg, 8'({4'd0, slot} << lg_req[2:0])};
        alloc_pool[hit_pg].used[slot] = 1'b1;
      end else if (ff_any) begin
        alloc_ok  = 1'b1;
        alloc_off = {ff_pg, 8'd0};
        alloc_pool[ff_pg].kind = psca_pkg::KIND_SPLIT;
        alloc_pool[ff_pg].lg   = lg_req[3:0];
        alloc_pool[ff_pg].used = 16'd1;
        alloc_pool[ff_pg].head = 1'b0;
      end
    end else if (lg_req <= psca_pkg::MULTI_LG && run_any) begin
      alloc_ok  = 1'b1;
      alloc_off = {run_pg, 8'd0};
      for (int k = 0; k < psca_pkg::PAGES; k++) begin
        if (4'(k) >= {1'b0, run_pg} && 4'(k) < {1'b0, run_pg} + n_pages) begin
          alloc_pool[k].kind = psca_pkg::KIND_MULTI;
          alloc_pool[k].lg   = lg_req[3:0];
          alloc_pool[k].head = (3'(k) == run_pg);
        end
      end
    end
  end

  // free of the latched offset
  logic [2:0]  fp;
  logic [7:0]  page_off;
  logic [3:0]  fj;
  logic [3:0]  fn;
  logic        free_ok;
  psca_pkg::page_t fe;
  always_comb begin
    fp        = boff[10:8];
    page_off  = boff[7:0];
    fe        = pool[fp];
    fj        = 4'(page_off >> fe.lg[2:0]);
    fn        = 4'd1 << fe.lg[1:0];
    free_pool = pool;
    free_ok   = 1'b0;
    if (fe.kind == psca_pkg::KIND_SPLIT) begin
      if ((page_off & ((8'd1 << fe.lg[2:0]) - 8'd1)) == 8'd0 && fe.used[fj]) begin
        free_ok = 1'b1;
        free_pool[fp].used[fj] = 1'b0;
        if ((fe.used & ~(16'd1 << fj)) == 16'd0) begin
          free_pool[fp].kind = psca_pkg::KIND_FREE;
          free_pool[fp].lg   = psca_pkg::PAGE_LG;
        end
      end
    end else if (fe.kind == psca_pkg::KIND_MULTI) begin
      if (page_off == 8'd0 && fe.head) begin
        free_ok = 1'b1;
        for (int k = 0; k < psca_pkg::PAGES; k++) begin
          if (4'(k) >= {1'b0, fp} && 4'(k) < {1'b0, fp} + fn) begin
            free_pool[k].kind = psca_pkg::KIND_FREE;
            free_pool[k].lg   = psca_pkg::PAGE_LG;
            free_pool[k].used = '0;
            free_pool[k].head = 1'b0;
          end
        end
      end
    end
  end

  logic same_class;
  assign same_class = (lg_req == {1'b0, snap[fp].lg});

  always_comb begin
    stat.free_ok  = free_ok;
    stat.out_busy = out_valid && !rsp.ready;
    if (func == psca_pkg::FUNC_ALLOC || (func == psca_pkg::FUNC_REALLOC && !present))
      stat.path = psca_pkg::PATH_ALLOC;
    else if (func == psca_pkg::FUNC_FREE)
      stat.path = psca_pkg::PATH_FREE;
    else if (func == psca_pkg::FUNC_REALLOC)
      stat.path = psca_pkg::PATH_REALLOC;
    else
      stat.path = psca_pkg::PATH_BAD;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func     <= req.func;
      req_size <= req.request_size;
      boff     <= req.block_offset;
      present  <= req.offset_present;
      snap     <= pool;
    end
    if (rst) begin
      for (int i = 0; i < psca_pkg::PAGES; i++) begin
        pool[i] <= '{kind: psca_pkg::KIND_FREE, lg: psca_pkg::PAGE_LG, used: '0, head: 1'b0};
      end
    end else if (cmd.do_alloc && alloc_ok) begin
      pool <= alloc_pool;
    end else if (cmd.do_free && free_ok) begin
      pool <= free_pool;
    end else if (cmd.do_realloc) begin
      if (same_class || !alloc_ok) pool <= snap;
      else                          pool <= alloc_pool;
    end
    if (cmd.do_alloc) begin
      res_off    <= alloc_ok ? alloc_off : 11'd0;
      res_status <= alloc_ok ? psca_pkg::ST_OK : psca_pkg::ST_NOSPACE;
    end
    if (cmd.do_free) begin
      res_off    <= free_ok ? 11'd0 : boff;
      res_status <= free_ok ? psca_pkg::ST_OK : psca_pkg::ST_BADOFF;
    end
    if (cmd.do_bad) begin
      res_off    <= 11'd0;
      res_status <= psca_pkg::ST_BADOFF;
    end
    if (cmd.do_realloc) begin
      if (same_class) begin
        res_off    <= boff;
        res_status <= psca_pkg::ST_OK;
      end else if (alloc_ok) begin
        res_off    <= alloc_off;
        res_status <= psca_pkg::ST_OK;
      end else begin
        res_off    <= boff;
        res_status <= psca_pkg::ST_NOSPACE;
      end
    end
    if (cmd.emit) begin
      out_off    <= res_off;
      out_status <= res_status;
    end
    if (rst)               out_valid <= 1'b0;
    else if (cmd.emit)     out_valid <= 1'b1;
    else if (rsp.ready)    out_valid <= 1'b0;
  end

  assign rsp.valid         = out_valid;
  assign rsp.result_offset = out_off;
  assign rsp.status        = out_status;

endmodule

/* rtl/page_size_class_allocator_unit.sv */
// Page size-class allocator: allocate, free and reallocate over eight pages.
// Response is registered. The sequencer walks an operation step (free or allocate), an
// allocate step for a reallocate whose old block frees, and a response step that waits
// on the output register; one request in flight, the next taken only back in idle.
// Reset (synchronous, rst high): all pages free, no response pending.
// Depends on psca_pkg, psca_if, psca_ctrl and psca_datapath.
module page_size_class_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  psca_req_if.sink    req,
  psca_rsp_if.source  rsp
);

  // Command and status between sequencer and datapath.
  psca_pkg::cmd_t  cmd;
  psca_pkg::stat_t stat;

  // Sequencer: takes a request beat in idle, then drives the datapath
  // through free and allocate steps and hands the result to the output
  // register once that register can take it.
  psca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: page table, snapshot for reallocate rollback, search logic
  // and the response register that holds a beat until it is taken.
  psca_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
